// File: rtl/gtt_pkg.sv
package gtt_pkg;

	localparam int unsigned CHANNELS = 3;
	localparam int unsigned DIV_CELLS = 8;

	localparam logic [7:0] FULL_SCALE = 8'd255;
	localparam logic [8:0] SPAN = 9'd256;

	typedef enum logic [2:0] {
		REG_SOURCE_RED   = 3'd0,
		REG_SOURCE_GREEN = 3'd1,
		REG_SOURCE_BLUE  = 3'd2,
		REG_TARGET_RED   = 3'd3,
		REG_TARGET_GREEN = 3'd4,
		REG_TARGET_BLUE  = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [7:0] in_red;
		logic [7:0] in_green;
		logic [7:0] in_blue;
		logic [7:0] in_alpha;
	} pixel_in_t;

	typedef struct packed {
		logic [7:0] out_red;
		logic [7:0] out_green;
		logic [7:0] out_blue;
		logic [7:0] out_alpha;
	} pixel_out_t;

	// per channel source and target levels, index 0 red, 1 green, 2 blue
	typedef struct packed {
		logic [CHANNELS-1:0][7:0] src;
		logic [CHANNELS-1:0][7:0] dst;
	} cfg_t;

	// one channel in flight through the divider chain:
	// rem is the partial remainder, nq holds the dividend bits not yet
	// consumed in its top and the quotient bits already found in its bottom
	typedef struct packed {
		logic [7:0] rem;
		logic [7:0] nq;
		logic [8:0] div;
		logic [7:0] off;
	} chan_t;

	typedef struct packed {
		chan_t [CHANNELS-1:0] ch;
		logic [7:0]           alpha;
	} work_t;

endpackage

// File: rtl/gtt_front.sv
module gtt_front (
	input  logic              clk,
	input  logic              arst_n,
	input  gtt_pkg::cfg_t     cfg,
	input  logic              in_vld,
	input  gtt_pkg::pixel_in_t in_pix,
	output logic              in_rdy,
	output logic              out_vld,
	output gtt_pkg::work_t    out_work,
	input  logic              out_rdy
);

	logic [gtt_pkg::CHANNELS-1:0][7:0]  smp;
	logic [gtt_pkg::CHANNELS-1:0]       upper;
	logic [gtt_pkg::CHANNELS-1:0][7:0]  op_a;
	logic [gtt_pkg::CHANNELS-1:0][7:0]  op_b;
	logic [gtt_pkg::CHANNELS-1:0][15:0] prod;
	gtt_pkg::work_t                     nxt;
	gtt_pkg::work_t                     work_s1;
	logic                               vld_s1;

	assign smp[0] = in_pix.in_red;
	assign smp[1] = in_pix.in_green;
	assign smp[2] = in_pix.in_blue;

	// upper piece: (255-dst)*(s-src) / (256-src) + dst
	// lower piece: dst*s / src
	always_comb begin
		for (int c = 0; c < gtt_pkg::CHANNELS; c++) begin
			upper[c] = smp[c] >= cfg.src[c];
			op_a[c]  = upper[c] ? (gtt_pkg::FULL_SCALE - cfg.dst[c]) : cfg.dst[c];
			op_b[c]  = upper[c] ? (smp[c] - cfg.src[c]) : smp[c];
			prod[c]  = op_a[c] * op_b[c];
			nxt.ch[c].rem = prod[c][15:8];
			nxt.ch[c].nq  = prod[c][7:0];
			nxt.ch[c].div = upper[c] ? (gtt_pkg::SPAN - {1'b0, cfg.src[c]})
				: {1'b0, cfg.src[c]};
			nxt.ch[c].off = upper[c] ? cfg.dst[c] : 8'd0;
		end
		nxt.alpha = in_pix.in_alpha;
	end

	assign in_rdy = !vld_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			work_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_work = work_s1;

endmodule

// File: rtl/gtt_cell.sv
module gtt_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_vld,
	input  gtt_pkg::work_t in_work,
	output logic           in_rdy,
	output logic           out_vld,
	output gtt_pkg::work_t out_work,
	input  logic           out_rdy
);

	logic [gtt_pkg::CHANNELS-1:0][8:0] trial;
	logic [gtt_pkg::CHANNELS-1:0]      take;
	gtt_pkg::work_t                    nxt;
	gtt_pkg::work_t                    work_s1;
	logic                              vld_s1;

	// one restoring step per channel: bring down the next dividend bit,
	// subtract the divisor if it fits, shift the quotient bit in
	always_comb begin
		nxt = in_work;
		for (int c = 0; c < gtt_pkg::CHANNELS; c++) begin
			trial[c] = {in_work.ch[c].rem, in_work.ch[c].nq[7]};
			take[c]  = trial[c] >= in_work.ch[c].div;
			nxt.ch[c].rem = take[c] ? 8'(trial[c] - in_work.ch[c].div) : trial[c][7:0];
			nxt.ch[c].nq  = {in_work.ch[c].nq[6:0], take[c]};
		end
	end

	assign in_rdy = !vld_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			work_s1 <= nxt;
		end
	end

	assign out_vld  = vld_s1;
	assign out_work = work_s1;

endmodule

// File: rtl/grey_to_tint_colour_remap.sv
// Stages: one multiply stage, eight divider cells, one output register, from
// input transfer to output valid. Throughput: one pixel per cycle while the
// output is not stalled; every stage moves on its own, so bubbles close up
// and a pixel is taken while a finished one waits at the output.
// Reset: all stage valids clear and all six level registers read zero.
module grey_to_tint_colour_remap (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  gtt_pkg::pixel_in_t  in_pixel,
	output logic                out_valid,
	input  logic                out_stall,
	output gtt_pkg::pixel_out_t out_pixel,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [7:0]          cfg_data
);

	localparam int unsigned LAST = gtt_pkg::DIV_CELLS;

	gtt_pkg::cfg_t       cfg_q;
	logic [LAST+1:0]     rdy;
	logic [LAST:0]       vld;
	gtt_pkg::work_t      work [LAST+1];
	gtt_pkg::pixel_out_t pix_s10;
	gtt_pkg::pixel_out_t pix_nxt;
	logic                vld_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				gtt_pkg::REG_SOURCE_RED:   cfg_q.src[0] <= cfg_data;
				gtt_pkg::REG_SOURCE_GREEN: cfg_q.src[1] <= cfg_data;
				gtt_pkg::REG_SOURCE_BLUE:  cfg_q.src[2] <= cfg_data;
				gtt_pkg::REG_TARGET_RED:   cfg_q.dst[0] <= cfg_data;
				gtt_pkg::REG_TARGET_GREEN: cfg_q.dst[1] <= cfg_data;
				gtt_pkg::REG_TARGET_BLUE:  cfg_q.dst[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	gtt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_vld   (in_valid),
		.in_pix   (in_pixel),
		.in_rdy   (rdy[0]),
		.out_vld  (vld[0]),
		.out_work (work[0]),
		.out_rdy  (rdy[1])
	);

	for (genvar k = 1; k <= LAST; k++) begin : g_cell
		gtt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_vld   (vld[k-1]),
			.in_work  (work[k-1]),
			.in_rdy   (rdy[k]),
			.out_vld  (vld[k]),
			.out_work (work[k]),
			.out_rdy  (rdy[k+1])
		);
	end

	assign in_stall = !rdy[0];

	// the quotient is below 256 and the offset plus quotient never wraps
	always_comb begin
		pix_nxt.out_red   = work[LAST].ch[0].off + work[LAST].ch[0].nq;
		pix_nxt.out_green = work[LAST].ch[1].off + work[LAST].ch[1].nq;
		pix_nxt.out_blue  = work[LAST].ch[2].off + work[LAST].ch[2].nq;
		pix_nxt.out_alpha = work[LAST].alpha;
	end

	assign rdy[LAST+1] = !vld_s10 || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s10 <= 1'b0;
		end else if (rdy[LAST+1]) begin
			vld_s10 <= vld[LAST];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[LAST+1] && vld[LAST]) begin
			pix_s10 <= pix_nxt;
		end
	end

	assign out_valid = vld_s10;
	assign out_pixel = pix_s10;

	// remainder below divisor on entry keeps every quotient within 8 bits
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] |-> (({1'b0, work[0].ch[0].rem} < work[0].ch[0].div)
			&& ({1'b0, work[0].ch[1].rem} < work[0].ch[1].div)
			&& ({1'b0, work[0].ch[2].rem} < work[0].ch[2].div)))
		else $error("dividend too large for an 8-bit quotient");

	a_no_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		vld[LAST] |-> (({1'b0, work[LAST].ch[0].off} + {1'b0, work[LAST].ch[0].nq} < 9'd256)
			&& ({1'b0, work[LAST].ch[1].off} + {1'b0, work[LAST].ch[1].nq} < 9'd256)
			&& ({1'b0, work[LAST].ch[2].off} + {1'b0, work[LAST].ch[2].nq} < 9'd256)))
		else $error("remapped level overflows 8 bits");

	a_front_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld[0] && !rdy[1] |=> vld[0] && $stable(work[0]))
		else $error("front stage dropped or changed a held pixel");

	a_last_holds: assert property (@(posedge clk) disable iff (!arst_n)
		vld[LAST] && !rdy[LAST+1] |=> vld[LAST] && $stable(work[LAST]))
		else $error("last divider cell dropped or changed a held pixel");

	a_take_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld[0] |-> !in_stall)
		else $error("input stalled with an empty front stage");

endmodule
